[hw/rtl/ipu_pkg.sv]
// Shared types and constants for the integer pixel upscaler.
package ipu_pkg;

    localparam int PIX_W         = 24;
    localparam int SCALE_W       = 4;
    localparam int WIDTH_CFG_W   = 12;
    localparam int CFG_DATA_W    = 12;
    localparam int CFG_INDEX_W   = 1;
    localparam int PAD_W         = 2;
    localparam int WIDTH_MAX_DEF = 2048;
    localparam int SCALE_MAX_DEF = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCALE        = 1'b0,
        REG_SOURCE_WIDTH = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        FUNC_PIXEL  = 1'b0,
        FUNC_REPLAY = 1'b1
    } func_t;

    // One accepted transaction, handed from the control stage to the emitter.
    typedef struct packed {
        logic               rejected;
        logic               use_mem;
        logic [PIX_W-1:0]   px;
        logic [SCALE_W-1:0] copies;
        logic               row_end;
        logic [PAD_W-1:0]   pad;
        logic               mode;
    } job_t;

endpackage

[hw/rtl/ipu_line_buffer.sv]
// Line buffer memory: one access per cycle, registered read data.
module ipu_line_buffer
    import ipu_pkg::*;
#(
    parameter int DEPTH = WIDTH_MAX_DEF,
    parameter int AW    = 11
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic             rd_en,
    input  logic [AW-1:0]    addr,
    input  logic [PIX_W-1:0] wr_data,
    output logic [PIX_W-1:0] rd_data
);

    logic [PIX_W-1:0] mem [0:DEPTH-1];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/ipu_ctrl.sv]
// Control stage: configuration, row and replay state, buffer access and job issue.
module ipu_ctrl
    import ipu_pkg::*;
#(
    parameter int WIDTH_MAX = WIDTH_MAX_DEF,
    parameter int SCALE_MAX = SCALE_MAX_DEF,
    parameter int AW        = 11
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   func,
    input  logic [7:0]             red_in,
    input  logic [7:0]             green_in,
    input  logic [7:0]             blue_in,
    output logic                   mem_wr_en,
    output logic                   mem_rd_en,
    output logic [AW-1:0]          mem_addr,
    output logic [PIX_W-1:0]       mem_wr_data,
    output logic                   job_valid,
    output job_t                   job,
    input  logic                   job_take
);

    localparam int CW  = (AW + 1 > WIDTH_CFG_W) ? AW + 1 : WIDTH_CFG_W;
    localparam int RW  = (SCALE_MAX > 1) ? $clog2(SCALE_MAX) : 1;
    localparam int RCW = (RW + 1 > SCALE_W) ? RW + 1 : SCALE_W;

    logic [SCALE_W-1:0]     scale_reg;
    logic [WIDTH_CFG_W-1:0] width_reg;
    logic [AW-1:0]          column_reg;
    logic [AW-1:0]          column_next;
    logic                   mode_reg;
    logic                   mode_next;
    logic [RW-1:0]          repeat_reg;
    logic [RW-1:0]          repeat_next;
    logic                   job_valid_reg;
    job_t                   job_reg;
    job_t                   job_next;

    logic [SCALE_W-1:0] scale_eff;
    logic [CW-1:0]      width_ext;
    logic [CW-1:0]      width_eff;
    logic               row_end;
    logic               replay_done;
    logic               accept;
    logic               mismatch;
    logic               do_work;
    logic [PIX_W-1:0]   pixel;

    always_comb
    begin
        if (scale_reg == '0)
        begin
            scale_eff = SCALE_W'(1);
        end
        else if (int'(scale_reg) > SCALE_MAX)
        begin
            scale_eff = SCALE_W'(SCALE_MAX);
        end
        else
        begin
            scale_eff = scale_reg;
        end
    end

    assign width_ext = CW'(width_reg);

    always_comb
    begin
        if (width_ext == '0)
        begin
            width_eff = CW'(1);
        end
        else if (width_ext > CW'(WIDTH_MAX))
        begin
            width_eff = CW'(WIDTH_MAX);
        end
        else
        begin
            width_eff = width_ext;
        end
    end

    assign row_end     = (CW'(column_reg) + CW'(1)) >= width_eff;
    assign replay_done = ((RCW'(repeat_reg) + RCW'(1)) >= (RCW'(scale_eff) - RCW'(1)))
                         || (scale_eff <= SCALE_W'(1));

    assign in_ready = !job_valid_reg || job_take;
    assign accept   = in_valid && in_ready;
    assign mismatch = (func != mode_reg);
    assign do_work  = accept && !mismatch;
    assign pixel    = {red_in, green_in, blue_in};

    assign mem_wr_en   = do_work && (func == FUNC_PIXEL);
    assign mem_rd_en   = do_work && (func == FUNC_REPLAY);
    assign mem_addr    = column_reg;
    assign mem_wr_data = pixel;

    always_comb
    begin
        column_next = column_reg;
        mode_next   = mode_reg;
        repeat_next = repeat_reg;
        if (row_end)
        begin
            column_next = '0;
            if (!mode_reg)
            begin
                if (scale_eff > SCALE_W'(1))
                begin
                    mode_next   = 1'b1;
                    repeat_next = '0;
                end
            end
            else if (replay_done)
            begin
                mode_next   = 1'b0;
                repeat_next = '0;
            end
            else
            begin
                repeat_next = repeat_reg + RW'(1);
            end
        end
        else
        begin
            column_next = column_reg + AW'(1);
        end
    end

    always_comb
    begin
        if (mismatch)
        begin
            // A transaction of the wrong kind yields a single rejection result.
            job_next.rejected = 1'b1;
            job_next.use_mem  = 1'b0;
            job_next.px       = '0;
            job_next.copies   = SCALE_W'(1);
            job_next.row_end  = 1'b0;
            job_next.pad      = '0;
            job_next.mode     = mode_reg;
        end
        else
        begin
            job_next.rejected = 1'b0;
            job_next.use_mem  = (func == FUNC_REPLAY);
            job_next.px       = pixel;
            job_next.copies   = scale_eff;
            job_next.row_end  = row_end;
            // Output row bytes are 3*w*s; padding to four is (w*s) mod 4.
            job_next.pad      = PAD_W'(width_eff[1:0] * scale_eff[1:0]);
            job_next.mode     = mode_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= SCALE_W'(1);
            width_reg     <= WIDTH_CFG_W'(1);
            column_reg    <= '0;
            mode_reg      <= 1'b0;
            repeat_reg    <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_SCALE:        scale_reg <= cfg_data[SCALE_W-1:0];
                    REG_SOURCE_WIDTH: width_reg <= cfg_data[WIDTH_CFG_W-1:0];
                    default:          ;
                endcase
            end
            if (do_work)
            begin
                column_reg <= column_next;
                mode_reg   <= mode_next;
                repeat_reg <= repeat_next;
            end
            if (accept)
            begin
                job_valid_reg <= 1'b1;
            end
            else if (job_take)
            begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

[hw/rtl/ipu_emit.sv]
// Emitter: gives out each job's pixel the required number of times, one per cycle while out_ready is high.
module ipu_emit
    import ipu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  job_t             job,
    input  logic [PIX_W-1:0] rd_data,
    output logic             job_take,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out,
    output logic [PAD_W-1:0] pad_bytes,
    output logic             row_end,
    output logic             last,
    output logic             rejected,
    output logic             replay_pending
);

    logic               e_valid_reg;
    job_t               e_job_reg;
    job_t               e_job_next;
    logic [SCALE_W-1:0] rem_reg;
    logic               e_last;
    logic               out_fire;
    logic               e_free;

    assign e_last   = (rem_reg == SCALE_W'(1));
    assign out_fire = e_valid_reg && out_ready;
    assign e_free   = !e_valid_reg || (out_fire && e_last);
    assign job_take = job_valid && e_free;

    always_comb
    begin
        e_job_next = job;
        if (job.use_mem)
        begin
            e_job_next.px = rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (job_take)
        begin
            e_valid_reg <= 1'b1;
        end
        else if (out_fire && e_last)
        begin
            e_valid_reg <= 1'b0;
        end
    end

    // The buffer read for a replay transaction is registered at the same edge as the job,
    // so its data is ready no later than the job can move here.
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            e_job_reg <= e_job_next;
            rem_reg   <= job.copies;
        end
        else if (out_fire && !e_last)
        begin
            rem_reg <= rem_reg - SCALE_W'(1);
        end
    end

    assign out_valid      = e_valid_reg;
    assign red_out        = e_job_reg.px[23:16];
    assign green_out      = e_job_reg.px[15:8];
    assign blue_out       = e_job_reg.px[7:0];
    assign row_end        = e_last && e_job_reg.row_end;
    assign pad_bytes      = row_end ? e_job_reg.pad : '0;
    assign last           = e_last;
    assign rejected       = e_job_reg.rejected;
    assign replay_pending = e_job_reg.mode;

endmodule

[hw/rtl/integer_pixel_upscaler_core.sv]
// Nearest-neighbour integer upscaler for 24-bit pixels. A pixel transaction is stored in the
// line buffer and given out scale times (1 to 8), one result per cycle while out_ready is high,
// and a rejected transaction gives a single result; the emitter's one-copy-per-cycle output
// sets this rate, and a new transaction is accepted while the previous one is still being given
// out. After the last pixel of a row (and with scale above one) the block expects replay
// transactions, each reading the next buffered pixel back through the memory's single port.
// The line buffer needs no clearing after reset.
module integer_pixel_upscaler_core
    import ipu_pkg::*;
#(
    parameter int WIDTH_MAX = WIDTH_MAX_DEF,
    parameter int SCALE_MAX = SCALE_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   func,
    input  logic [7:0]             red_in,
    input  logic [7:0]             green_in,
    input  logic [7:0]             blue_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             red_out,
    output logic [7:0]             green_out,
    output logic [7:0]             blue_out,
    output logic [PAD_W-1:0]       pad_bytes,
    output logic                   row_end,
    output logic                   last,
    output logic                   rejected,
    output logic                   replay_pending
);

    localparam int AW = (WIDTH_MAX > 1) ? $clog2(WIDTH_MAX) : 1;

    logic             mem_wr_en;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_addr;
    logic [PIX_W-1:0] mem_wr_data;
    logic [PIX_W-1:0] mem_rd_data;
    logic             job_valid;
    job_t             job;
    logic             job_take;

    ipu_ctrl #(
        .WIDTH_MAX (WIDTH_MAX),
        .SCALE_MAX (SCALE_MAX),
        .AW        (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .mem_wr_en   (mem_wr_en),
        .mem_rd_en   (mem_rd_en),
        .mem_addr    (mem_addr),
        .mem_wr_data (mem_wr_data),
        .job_valid   (job_valid),
        .job         (job),
        .job_take    (job_take)
    );

    ipu_line_buffer #(
        .DEPTH (WIDTH_MAX),
        .AW    (AW)
    ) u_line_buffer (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    ipu_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (job_valid),
        .job            (job),
        .rd_data        (mem_rd_data),
        .job_take       (job_take),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .pad_bytes      (pad_bytes),
        .row_end        (row_end),
        .last           (last),
        .rejected       (rejected),
        .replay_pending (replay_pending)
    );

endmodule

[hw/rtl/ipu_checker.sv]
// Port-level checker for the upscaler core and its bind statement.
module ipu_checker
    import ipu_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [7:0]       red_out,
    input logic [7:0]       green_out,
    input logic [7:0]       blue_out,
    input logic [PAD_W-1:0] pad_bytes,
    input logic             row_end,
    input logic             last,
    input logic             rejected
);

    // A rejection is a single, blank result.
    a_reject_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> last && !row_end && pad_bytes == '0
            && red_out == 8'h00 && green_out == 8'h00 && blue_out == 8'h00)
        else $error("rejected result is not a blank final result");

    // Padding is only reported where an output row closes.
    a_pad_at_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pad_bytes != '0 |-> row_end)
        else $error("padding reported away from a row end");

    // A row can only close on the final copy of a transaction.
    a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_end |-> last)
        else $error("row end on a result that is not the last of its transaction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(last) && $stable(rejected))
        else $error("stalled result changed or was withdrawn");

endmodule

bind integer_pixel_upscaler_core ipu_checker u_ipu_checker (.*);
